/* src/cqrf_pkg.sv */
package cqrf_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 5;
    localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_GENERATE = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic signed [31:0] stop_value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] head_value;
        logic [4:0]         placed_count;
        logic [4:0]         occupancy;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [31:0]      wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    // ring advance: wraps at the configured capacity, not at DEPTH
    function automatic logic [IDX_W-1:0] cqrf_next_idx(input logic [IDX_W-1:0] idx,
                                                       input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] inc;
        inc = (CNT_W + 1)'(idx) + (CNT_W + 1)'(1);
        return (inc >= (CNT_W + 1)'(cap)) ? '0 : inc[IDX_W-1:0];
    endfunction

endpackage

/* src/cqrf_step.sv */
module cqrf_step
    import cqrf_pkg::*;
(
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_stop,
    output logic signed [31:0] o_next,
    output logic               o_eq
);

    logic gt;

    // one adder: step by +1 or -1 toward the stop value
    assign gt     = (i_value > i_stop);
    assign o_eq   = (i_value == i_stop);
    assign o_next = i_value + (gt ? -32'sd1 : 32'sd1);

endmodule

/* src/cqrf_mem.sv */
module cqrf_mem
    import cqrf_pkg::*;
(
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_rd_data
);

    logic [31:0] r_slots [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_slots[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_slots[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/cqrf_seq.sv */
module cqrf_seq
    import cqrf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_mem_req         o_mem,
    input  logic [31:0]      i_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_cap, n_cap;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    t_op                r_op, n_op;
    logic signed [31:0] r_val, n_val;
    logic signed [31:0] r_stop, n_stop;
    logic [4:0]         r_placed, n_placed;
    t_status            r_status, n_status;
    logic signed [31:0] r_headval, n_headval;

    logic               full;
    logic [IDX_W-1:0]   tail_adv;
    logic [IDX_W-1:0]   head_adv;
    logic [CNT_W-1:0]   cap_clamp;
    logic [CNT_W-1:0]   cap_m1;
    logic signed [31:0] step_next;
    logic               step_eq;

    cqrf_step u_step (
        .i_value (r_val),
        .i_stop  (r_stop),
        .o_next  (step_next),
        .o_eq    (step_eq)
    );

    assign full     = (r_count >= r_cap);
    assign tail_adv = cqrf_next_idx(r_tail, r_cap);
    assign head_adv = cqrf_next_idx(r_head, r_cap);

    always_comb begin
        if (i_cfg_data == '0) begin
            cap_clamp = CNT_W'(1);
        end else if (int'(i_cfg_data) > DEPTH) begin
            cap_clamp = CNT_W'(DEPTH);
        end else begin
            cap_clamp = CNT_W'(i_cfg_data);
        end
        cap_m1 = cap_clamp - CNT_W'(1);
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_cap       = r_cap;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_op        = r_op;
        n_val       = r_val;
        n_stop      = r_stop;
        n_placed    = r_placed;
        n_status    = r_status;
        n_headval   = r_headval;
        o_mem       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_cap   = cap_clamp;
                    n_head  = '0;
                    n_tail  = cap_m1[IDX_W-1:0];
                    n_count = '0;
                end else if (i_in_valid) begin
                    n_op      = i_in_data.op;
                    n_val     = i_in_data.value;
                    n_stop    = i_in_data.stop_value;
                    n_placed  = '0;
                    n_status  = ST_OK;
                    n_headval = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op) inside
                    OP_INSERT, OP_GENERATE: begin
                        if (full) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = tail_adv;
                            o_mem.wdata = r_val;
                            n_tail      = tail_adv;
                            n_count     = r_count + CNT_W'(1);
                            n_placed    = r_placed + 5'd1;
                            // insert is a run of one
                            if (r_op == OP_INSERT || step_eq) begin
                                n_state = S_DONE;
                            end else begin
                                n_val = step_next;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = r_head;
                            n_head      = head_adv;
                            n_count     = r_count - CNT_W'(1);
                            n_state     = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                n_headval = i_rd_data;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status       = r_status;
                    n_out.head_value   = r_headval;
                    n_out.placed_count = r_placed;
                    n_out.occupancy    = 5'(r_count);
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= IDX_W'(CAP_RESET - 1);
            r_count     <= '0;
            r_cap       <= CNT_W'(CAP_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
        r_out     <= n_out;
        r_op      <= n_op;
        r_val     <= n_val;
        r_stop    <= n_stop;
        r_placed  <= n_placed;
        r_status  <= n_status;
        r_headval <= n_headval;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/circular_queue_with_range_fill.sv */
// Circular FIFO of signed 32-bit words with a run generator.
// Input channel (i_in_valid/o_in_ready/i_in_data) carries one operation per
// beat: insert a word, remove the head word, append the run from value
// toward stop_value in steps of one, or do nothing (OP_NONE). Each operation
// yields exactly one result beat on o_out_valid/i_out_ready/o_out_data:
// status, removed word, count appended and occupancy after the operation.
// Config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) sets the capacity
// (0 acts as 1, above DEPTH acts as DEPTH) and empties the queue.
// Path from input beat to result valid: insert runs through the execute and
// done states, remove adds a registered slot read state, and generate stays in
// execute until the run reaches stop_value or a full queue cuts it short.
// The next input beat can be taken in the same cycle that the result goes
// valid. One operation is in flight at a time; while the queue has room, the
// generator appends one word per cycle through the one +/-1 adder and the
// single slot write port, which sets the run rate.
// The result sits in an output register, so the next input beat is taken
// while an earlier result waits; a stalled receiver holds the sequencer in its
// final state only once a second result is ready.
// Reset: capacity 16, queue empty. Slot contents are not cleared.
module circular_queue_with_range_fill
    import cqrf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_mem_req    mem_req;
    logic [31:0] rd_data;

    cqrf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    cqrf_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule

/* src/cqrf_checker.sv */
module cqrf_checker
    import cqrf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input t_in_item         i_in_data,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_item        o_out_data,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [CFG_W-1:0] i_cfg_data
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // one operation at a time: busy right after taking a beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an operation is in flight");

    // an empty remove places nothing, returns zero and leaves the queue empty
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_EMPTY) |->
        (o_out_data.head_value == '0) && (o_out_data.placed_count == '0) &&
        (o_out_data.occupancy == '0))
        else $error("empty status with nonzero fields");

    // bounded counts: occupancy within DEPTH, placed count within occupancy, no reserved status
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out_data.occupancy) <= DEPTH) &&
        (o_out_data.placed_count <= o_out_data.occupancy) &&
        (o_out_data.status != ST_RSVD))
        else $error("result counts out of range");

endmodule

bind circular_queue_with_range_fill cqrf_checker u_cqrf_checker (.*);
